@@ rtl/fust_pkg.sv @@
// ----------------------------------------------------------------------------
// fust_pkg
// Shared types and constants for the first unique symbol tracker.
// ----------------------------------------------------------------------------
package fust_pkg;

  // Default width of a symbol index. The order and count stores hold
  // 2**SYMBOL_BITS entries.
  localparam int unsigned SYMBOL_BITS_DEFAULT = 8;

  // Width of the symbol fields on the stream ports.
  localparam int unsigned DATA_BITS = 8;

  // Occurrence count codes, saturating at "many".
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONCE = 2'd1;
  localparam logic [1:0] CNT_MANY = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_HEAD_CHK,
    ST_HEAD_ORD,
    ST_HEAD_CNT,
    ST_DONE_FOUND,
    ST_DONE_NONE
  } fust_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_write;    // write CNT_NONE at the clearing index
    logic accept;       // latch the input symbol and read its count
    logic cnt_update;   // write the new count, append on first arrival
    logic ord_rd_head;  // read the order entry at the head
    logic cnt_rd_head;  // read the count of the symbol at the head
    logic head_inc;     // step the head past a repeated symbol
    logic out_load;     // load the result register
    logic out_found;    // result carries a symbol
  } fust_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;     // clearing index is at the last entry
    logic cnt_many;     // count read data says repeated
    logic head_lt_tail; // the order store holds a candidate at the head
    logic out_free;     // result register can take a new result
  } fust_status_t;

endpackage

@@ rtl/first_unique_symbol_tracker_top.sv @@
// Sequence: an accepted input transaction reads its count, writes the updated count,
//   then steps the head past each repeated order entry before its result is loaded.
// Flow: a new transaction is taken only after the previous result has been loaded,
//   and each entry is skipped at most once, so the long-run cost stays bounded.
// Reset: synchronous, active high; afterwards a clearing pass over all 2**SYMBOL_BITS
//   entries zeroes the count store before s_tready rises.
// ----------------------------------------------------------------------------
// first_unique_symbol_tracker_top
// Reports the earliest symbol of a byte stream that has so far occurred
// exactly once, one result transaction per input transaction.
// ----------------------------------------------------------------------------
module first_unique_symbol_tracker_top #(
  // Width of the symbol index; the stores hold 2**SYMBOL_BITS entries.
  parameter int unsigned SYMBOL_BITS = fust_pkg::SYMBOL_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fust_pkg::DATA_BITS-1:0] s_tdata,  // [7:0] symbol
  // Result stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [fust_pkg::DATA_BITS-1:0] m_tdata,  // [7:0] first_unique
  output logic [0:0]                     m_tuser   // [0] found
);

  // The controller walks each transaction through a fixed sequence: read the
  // symbol's count, write the updated count (appending the symbol to the
  // arrival order store on its first arrival), then advance the head pointer
  // past every entry whose symbol has since repeated. The result register
  // decouples the output side, so a finished result may wait while the
  // controller returns to idle and takes the next transaction.
  fust_pkg::fust_cmd_t    cmd;
  fust_pkg::fust_status_t status;

  fust_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds both memories, the head and tail pointers, the
  // clearing counter and the result register.
  fust_datapath #(
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .status   (status)
  );

`ifndef SYNTHESIS
  // The count update follows an accepted transaction in the very next cycle.
  a_update_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> cmd.cnt_update)
    else $error("count update did not follow an accepted transaction");

  // The head pointer never steps beyond the tail.
  a_head_below_tail: assert property (@(posedge clk) disable iff (rst)
    cmd.head_inc |-> status.head_lt_tail)
    else $error("head pointer advanced past the tail");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten while still pending");

  // A result reporting no unique symbol carries a zero symbol.
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && !cmd.out_found) |=> (m_tdata == '0 && m_tuser == 1'b0))
    else $error("empty result carries a non-zero symbol");
`endif

endmodule

@@ rtl/fust_ram.sv @@
// ----------------------------------------------------------------------------
// fust_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module fust_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/fust_ctrl.sv @@
// ----------------------------------------------------------------------------
// fust_ctrl
// Sequencer: clearing pass, count update, head advance and result hand-off.
// ----------------------------------------------------------------------------
module fust_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  fust_pkg::fust_status_t status,
  output fust_pkg::fust_cmd_t   cmd
);

  fust_pkg::fust_state_t state;
  fust_pkg::fust_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fust_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      fust_pkg::ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (status.clr_last) begin
          state_next = fust_pkg::ST_IDLE;
        end
      end
      fust_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = fust_pkg::ST_UPDATE;
        end
      end
      fust_pkg::ST_UPDATE: begin
        cmd.cnt_update = 1'b1;
        state_next     = fust_pkg::ST_HEAD_CHK;
      end
      fust_pkg::ST_HEAD_CHK: begin
        if (status.head_lt_tail) begin
          cmd.ord_rd_head = 1'b1;
          state_next      = fust_pkg::ST_HEAD_ORD;
        end else begin
          state_next = fust_pkg::ST_DONE_NONE;
        end
      end
      fust_pkg::ST_HEAD_ORD: begin
        cmd.cnt_rd_head = 1'b1;
        state_next      = fust_pkg::ST_HEAD_CNT;
      end
      fust_pkg::ST_HEAD_CNT: begin
        if (status.cnt_many) begin
          cmd.head_inc = 1'b1;
          state_next   = fust_pkg::ST_HEAD_CHK;
        end else begin
          state_next = fust_pkg::ST_DONE_FOUND;
        end
      end
      fust_pkg::ST_DONE_FOUND: begin
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_found = 1'b1;
          state_next    = fust_pkg::ST_IDLE;
        end
      end
      fust_pkg::ST_DONE_NONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = fust_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fust_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/fust_datapath.sv @@
// ----------------------------------------------------------------------------
// fust_datapath
// Count store, arrival order store, head and tail pointers, result register.
// ----------------------------------------------------------------------------
module fust_datapath #(
  parameter int unsigned SYMBOL_BITS = fust_pkg::SYMBOL_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [fust_pkg::DATA_BITS-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [fust_pkg::DATA_BITS-1:0] m_tdata,
  output logic [0:0]                     m_tuser,
  input  fust_pkg::fust_cmd_t            cmd,
  output fust_pkg::fust_status_t         status
);

  localparam int unsigned Depth = 2 ** SYMBOL_BITS;

  logic [SYMBOL_BITS-1:0] sym_in;
  logic [SYMBOL_BITS-1:0] sym_q;
  logic [SYMBOL_BITS-1:0] clr_idx;
  logic [SYMBOL_BITS:0]   tail;
  logic [SYMBOL_BITS:0]   head;

  logic                   cnt_we;
  logic [SYMBOL_BITS-1:0] cnt_waddr;
  logic [1:0]             cnt_wdata;
  logic                   cnt_re;
  logic [SYMBOL_BITS-1:0] cnt_raddr;
  logic [1:0]             cnt_rdata;

  logic                   append;
  logic [SYMBOL_BITS-1:0] ord_rdata;

  // Input bits above the symbol width are dropped.
  assign sym_in = SYMBOL_BITS'(s_tdata);

  // A symbol is appended on its first arrival while the store has room.
  assign append = cmd.cnt_update && (cnt_rdata == fust_pkg::CNT_NONE) && !tail[SYMBOL_BITS];

  assign cnt_we    = cmd.clr_write | cmd.cnt_update;
  assign cnt_waddr = cmd.clr_write ? clr_idx : sym_q;
  assign cnt_wdata = cmd.clr_write ? fust_pkg::CNT_NONE :
                     (cnt_rdata == fust_pkg::CNT_NONE) ? fust_pkg::CNT_ONCE :
                     fust_pkg::CNT_MANY;
  assign cnt_re    = cmd.accept | cmd.cnt_rd_head;
  assign cnt_raddr = cmd.cnt_rd_head ? ord_rdata : sym_in;

  fust_ram #(
    .WIDTH(2),
    .DEPTH(Depth)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  fust_ram #(
    .WIDTH(SYMBOL_BITS),
    .DEPTH(Depth)
  ) u_order_ram (
    .clk   (clk),
    .we    (append),
    .waddr (tail[SYMBOL_BITS-1:0]),
    .wdata (sym_q),
    .re    (cmd.ord_rd_head),
    .raddr (head[SYMBOL_BITS-1:0]),
    .rdata (ord_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      tail     <= '0;
      head     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr_write) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (append) begin
        tail <= tail + 1'b1;
      end
      if (cmd.head_inc) begin
        head <= head + 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sym_q <= sym_in;
    end
    if (cmd.out_load) begin
      m_tdata <= cmd.out_found ? fust_pkg::DATA_BITS'(ord_rdata) : '0;
      m_tuser <= cmd.out_found;
    end
  end

  assign status.clr_last     = &clr_idx;
  assign status.cnt_many     = (cnt_rdata == fust_pkg::CNT_MANY);
  assign status.head_lt_tail = (head < tail);
  assign status.out_free     = !m_tvalid || m_tready;

endmodule

@@ tb/first_unique_symbol_tracker_top_tb.sv @@
// ----------------------------------------------------------------------------
// first_unique_symbol_tracker_top_tb
// Self-checking bench for the first unique symbol tracker. A short table of
// directed symbols runs first. A long random stream follows. That stream is
// biased towards fresh symbols and towards repeats of the current answer, so
// the order store fills and the head pointer makes long skips. Every result
// transaction is checked field by field against a typed value or a local model.
// ----------------------------------------------------------------------------
module first_unique_symbol_tracker_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Symbol index width of the block and width of the stream symbol fields.
  localparam int unsigned SYM_BITS  = fust_pkg::SYMBOL_BITS_DEFAULT;
  localparam int unsigned PTR_BITS  = SYM_BITS + 1;
  localparam int unsigned DATA_BITS = fust_pkg::DATA_BITS;

  // Number of symbol values, fixed by the 8-bit symbol index of the block.
  localparam int unsigned NUM_SYMBOLS = 1 << SYM_BITS;

  // Random transactions in each of the three traffic phases.
  localparam int unsigned PHASE_ITEMS = 180;

  // This many consecutive cycles without any accepted transaction ends the
  // run. The limit covers the clearing pass after reset, which writes all 256
  // count entries. It also covers a worst-case head skip over the whole order
  // store. Long random stalls on either side add to both, so the limit is set
  // well above their sum.
  localparam int unsigned STALL_LIMIT = 5000;

  // Cycles that are allowed to pass after the last expected result. They
  // catch any stray transaction that follows it.
  localparam int unsigned DRAIN_CYCLES = 24;

  // One result as the block should present it.
  typedef struct packed {
    logic [DATA_BITS-1:0] first_unique;
    logic                 found;
  } unique_result_t;

  // One row of the directed table. Where typed is set, the expected result
  // stands in the row. Otherwise the local model supplies it.
  typedef struct packed {
    logic [DATA_BITS-1:0] symbol;
    logic                 typed;
    logic [DATA_BITS-1:0] first_unique;
    logic                 found;
  } symbol_row_t;

  localparam int unsigned NUM_ROWS = 21;

  localparam symbol_row_t SYMBOL_TABLE [NUM_ROWS] = '{
    // The zero symbol straight after reset is a genuine answer.
    '{8'h00, 1'b1, 8'h00, 1'b1},
    // Its repeat leaves no unique symbol at all.
    '{8'h00, 1'b1, 8'h00, 1'b0},
    // The top symbol behaves in the same way.
    '{8'hFF, 1'b1, 8'hFF, 1'b1},
    '{8'hFF, 1'b1, 8'h00, 1'b0},
    '{8'h41, 1'b1, 8'h41, 1'b1},
    '{8'h42, 1'b0, 8'h00, 1'b0},
    '{8'h43, 1'b0, 8'h00, 1'b0},
    // A repeat behind the head does not move the answer.
    '{8'h42, 1'b0, 8'h00, 1'b0},
    // A repeat of the head skips over the repeated entry behind it.
    '{8'h41, 1'b0, 8'h00, 1'b0},
    '{8'h43, 1'b0, 8'h00, 1'b0},
    // Alternating bit patterns, then fresh symbols near both ends.
    '{8'hAA, 1'b0, 8'h00, 1'b0},
    '{8'h55, 1'b0, 8'h00, 1'b0},
    '{8'h01, 1'b0, 8'h00, 1'b0},
    '{8'h80, 1'b0, 8'h00, 1'b0},
    '{8'h7F, 1'b0, 8'h00, 1'b0},
    '{8'hFE, 1'b0, 8'h00, 1'b0},
    // A third arrival must leave the count saturated at "many".
    '{8'h55, 1'b0, 8'h00, 1'b0},
    '{8'h55, 1'b0, 8'h00, 1'b0},
    // Killing the head now skips both the head and the saturated entry.
    '{8'hAA, 1'b0, 8'h00, 1'b0},
    '{8'h80, 1'b0, 8'h00, 1'b0},
    '{8'h01, 1'b0, 8'h00, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [DATA_BITS-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [DATA_BITS-1:0] m_tdata;
  logic [0:0]           m_tuser;

  first_unique_symbol_tracker_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] symbol
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] first_unique
    .m_tuser  (m_tuser)    // [0] found
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local model of the tracker: per-symbol counts that saturate at "many", the
  // symbols in order of first arrival, and the tail and head of that order.
  // ---------------------------------------------------------------------------
  logic [1:0]          symbol_count [NUM_SYMBOLS];
  logic [SYM_BITS-1:0] arrival_symbol [NUM_SYMBOLS];
  logic [SYM_BITS:0]   arrival_tail;
  logic [SYM_BITS:0]   arrival_head;

  // Expected results, oldest first.
  unique_result_t pending_results [$];

  // Traffic shaping: chance in a hundred that a side idles in a given cycle.
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;

  int unsigned mismatches      = 0;
  int unsigned symbols_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned none_results    = 0;
  int unsigned longest_skip    = 0;
  int unsigned stall_cycles    = 0;

  initial begin
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      symbol_count[i]   = fust_pkg::CNT_NONE;
      arrival_symbol[i] = '0;
    end
    arrival_tail = '0;
    arrival_head = '0;
  end

  // Applies one symbol to the model and returns the answer that follows it.
  function automatic unique_result_t track_symbol(input logic [DATA_BITS-1:0] symbol);
    unique_result_t answer;
    int unsigned    skipped;
    skipped = 0;
    if (symbol_count[symbol] == fust_pkg::CNT_NONE) begin
      // A first arrival is appended. The store can never overflow, because
      // each symbol is appended only once.
      arrival_symbol[arrival_tail[SYM_BITS-1:0]] = symbol;
      arrival_tail = arrival_tail + 1'b1;
      symbol_count[symbol] = fust_pkg::CNT_ONCE;
    end else begin
      symbol_count[symbol] = fust_pkg::CNT_MANY;
    end
    // Move the head past every entry whose symbol has since repeated.
    while (arrival_head < arrival_tail &&
           symbol_count[arrival_symbol[arrival_head[SYM_BITS-1:0]]] ==
           fust_pkg::CNT_MANY) begin
      arrival_head = arrival_head + 1'b1;
      skipped++;
    end
    if (skipped > longest_skip) longest_skip = skipped;
    if (arrival_head < arrival_tail) begin
      answer.first_unique = arrival_symbol[arrival_head[SYM_BITS-1:0]];
      answer.found        = 1'b1;
    end else begin
      answer.first_unique = '0;
      answer.found        = 1'b0;
    end
    return answer;
  endfunction

  // Chooses the next random symbol. Fresh symbols fill the order store.
  // Repeats of the head make it move. Repeats of entries further back set
  // up long skips later on. A share of plain random symbols adds noise.
  function automatic logic [DATA_BITS-1:0] choose_symbol();
    int unsigned          roll;
    logic [SYM_BITS-1:0]  start;
    logic [SYM_BITS-1:0]  probe;
    logic [PTR_BITS-1:0]  pick;
    logic [DATA_BITS-1:0] candidate;
    roll      = $urandom_range(0, 99);
    candidate = DATA_BITS'($urandom_range(0, NUM_SYMBOLS - 1));
    if (roll < 45 && arrival_tail < NUM_SYMBOLS) begin
      start = SYM_BITS'($urandom_range(0, NUM_SYMBOLS - 1));
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
        // The probe wraps round the symbol range.
        probe = start + SYM_BITS'(i);
        if (symbol_count[probe] == fust_pkg::CNT_NONE) begin
          candidate = DATA_BITS'(probe);
          break;
        end
      end
    end else if (roll < 70 && arrival_head < arrival_tail) begin
      candidate = DATA_BITS'(arrival_symbol[arrival_head[SYM_BITS-1:0]]);
    end else if (roll < 88 && arrival_head < arrival_tail) begin
      pick      = PTR_BITS'($urandom_range(arrival_head, arrival_tail - 1'b1));
      candidate = DATA_BITS'(arrival_symbol[pick[SYM_BITS-1:0]]);
    end
    return candidate;
  endfunction

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Offers one symbol on the input stream. The task is entered and left just
  // after a falling edge. Any random idle cycles come before tvalid rises.
  // Once raised, tvalid stays high until the transaction is taken. When the
  // symbol is accepted, its expected result is queued, either the row's
  // typed value or the model's answer.
  task automatic send_symbol(input logic [DATA_BITS-1:0] symbol, input logic typed,
                             input unique_result_t typed_result);
    unique_result_t modelled;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= symbol;
    do @(posedge clk); while (s_tready !== 1'b1);
    modelled = track_symbol(symbol);
    pending_results.push_back(typed ? typed_result : modelled);
    symbols_sent++;
    @(negedge clk);
  endtask

  // The receiver's ready changes on falling edges only and stays low in reset.
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // Result checker: each result transaction is set against the oldest
  // expectation, one field at a time.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no expectation (tdata)", 32'(m_tdata), 0);
      end else begin
        if (m_tdata !== pending_results[0].first_unique)
          report_mismatch("first_unique", 32'(m_tdata),
                          32'(pending_results[0].first_unique));
        if (m_tuser[0] !== pending_results[0].found)
          report_mismatch("found", 32'(m_tuser[0]), 32'(pending_results[0].found));
        if (!pending_results[0].found) none_results++;
        void'(pending_results.pop_front());
        results_checked++;
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction on either side means
  // the block has hung.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("first_unique_symbol_tracker_top regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // After reset the block clears its count store before it raises
    // s_tready, and the sender simply waits on that.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, with the sender eager and a heavily stalled receiver.
    sender_idle_pct   = 12;
    receiver_idle_pct = 77;
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_symbol(SYMBOL_TABLE[r].symbol, SYMBOL_TABLE[r].typed,
                  unique_result_t'{SYMBOL_TABLE[r].first_unique, SYMBOL_TABLE[r].found});
    end

    // Random stream in three traffic phases. The first keeps the block's
    // output backed up. The second starves its input. The third runs at
    // full rate with no idling on either side.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 12;
          receiver_idle_pct = 77;
        end
        1: begin
          sender_idle_pct   = 77;
          receiver_idle_pct = 12;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_symbol(choose_symbol(), 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    // Let every expected result arrive, then watch a little longer for
    // strays. The watchdog guards both waits.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d symbols (%0d distinct), checked %0d results, %0d with none.",
             symbols_sent, arrival_tail, results_checked, none_results);
    $display("Longest single head skip: %0d entries; mismatches: %0d.",
             longest_skip, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("first_unique_symbol_tracker_top regression: pass");
    end else begin
      $display("first_unique_symbol_tracker_top regression: fail");
    end
    $finish;
  end

endmodule
